// File: src/lspos_pkg.sv
// ----------------------------------------------------------------------------
// lspos_pkg
// Shared codes, field widths and the control/status bundles between the
// last-substring-position controller and datapath.
// ----------------------------------------------------------------------------
package lspos_pkg;

    localparam int KIND_W = 2;
    localparam int BYTE_W = 8;
    localparam int OFS_W  = 14;
    localparam int POS_W  = 13;
    localparam int STAT_W = 2;

    // word kinds
    localparam logic [KIND_W-1:0] KIND_NEEDLE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_HAYSTACK = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FINISH   = 2'd2;

    // result status codes
    localparam logic [STAT_W-1:0] ST_FOUND = 2'd0;
    localparam logic [STAT_W-1:0] ST_NONE  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;
    localparam logic [STAT_W-1:0] ST_LONG  = 2'd3;

    // controller -> datapath
    typedef struct packed {
        logic load;    // append a byte word
        logic start;   // finish word taken, capture offset
        logic setup;   // bound the candidate range
        logic step;    // compare one byte pair
        logic finish;  // move result to output, clear strings
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic early;      // result known without searching
        logic match;      // current byte pair equal
        logic last_byte;  // current byte is the needle's last
        logic at_lo;      // candidate is the earliest allowed
        logic out_free;   // output register can take a result
    } t_sts;

endpackage

// File: src/lspos_ram.sv
// ----------------------------------------------------------------------------
// lspos_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lspos_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [AW-1:0]        i_wr_addr,
    input  logic [WIDTH-1:0]     i_wr_data,
    input  logic [AW-1:0]        i_rd_addr,
    output logic [WIDTH-1:0]     o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: src/lspos_ctrl.sv
// ----------------------------------------------------------------------------
// lspos_ctrl
// Sequencer: takes words while idle, then walks setup, read/compare pairs
// and result hand-off for a finish word.
// ----------------------------------------------------------------------------
module lspos_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [lspos_pkg::KIND_W-1:0] i_kind,
    output logic                         o_stall,
    input  lspos_pkg::t_sts              i_sts,
    output lspos_pkg::t_cmd              o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SETUP = 5'b00010,
        S_READ  = 5'b00100,
        S_CMP   = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    lspos_pkg::t_cmd cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_kind == lspos_pkg::KIND_FINISH) begin
                        cmd.start = 1'b1;
                        n_state   = S_SETUP;
                    end else begin
                        cmd.load = 1'b1;
                    end
                end
            end
            S_SETUP: begin
                cmd.setup = 1'b1;
                n_state   = i_sts.early ? S_DONE : S_READ;
            end
            S_READ: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                cmd.step = 1'b1;
                if ((i_sts.match && i_sts.last_byte) || (!i_sts.match && i_sts.at_lo)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_READ;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    cmd.finish = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_cmd   = cmd;

endmodule

// File: src/lspos_dp.sv
// ----------------------------------------------------------------------------
// lspos_dp
// String stores, lengths, search range setup, candidate walk and the
// output register.
// ----------------------------------------------------------------------------
module lspos_dp #(
    parameter int MAX_HAYSTACK = 4096,
    parameter int MAX_NEEDLE   = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [lspos_pkg::KIND_W-1:0]        i_kind,
    input  logic [lspos_pkg::BYTE_W-1:0]        i_byte_value,
    input  logic signed [lspos_pkg::OFS_W-1:0]  i_search_offset,
    input  logic                                i_stall,
    input  lspos_pkg::t_cmd                     i_cmd,
    output lspos_pkg::t_sts                     o_sts,
    output logic                                o_valid,
    output logic signed [lspos_pkg::POS_W-1:0]  o_position,
    output logic [lspos_pkg::STAT_W-1:0]        o_status
);

    localparam int HL_W = $clog2(MAX_HAYSTACK + 1);
    localparam int NL_W = $clog2(MAX_NEEDLE + 1);
    localparam int HA_W = (MAX_HAYSTACK > 1) ? $clog2(MAX_HAYSTACK) : 1;
    localparam int NA_W = (MAX_NEEDLE > 1) ? $clog2(MAX_NEEDLE) : 1;
    localparam int SW   = ((HL_W > lspos_pkg::OFS_W) ? HL_W : lspos_pkg::OFS_W) + 2;
    localparam int HW   = HL_W + NL_W;

    logic [HL_W-1:0]                     r_hay_len;
    logic [NL_W-1:0]                     r_ndl_len;
    logic                                r_ovf;
    logic signed [lspos_pkg::OFS_W-1:0]  r_ofs;
    logic [HA_W-1:0]                     r_cand;
    logic [HA_W-1:0]                     r_lo;
    logic [NA_W-1:0]                     r_k;
    logic [lspos_pkg::POS_W-1:0]         r_res_pos;
    logic [lspos_pkg::STAT_W-1:0]        r_res_status;
    logic                                r_out_valid;
    logic signed [lspos_pkg::POS_W-1:0]  r_out_pos;
    logic [lspos_pkg::STAT_W-1:0]        r_out_status;

    logic                       hay_full, ndl_full, hay_we, ndl_we;
    logic [HA_W-1:0]            hay_rd_addr;
    logic [lspos_pkg::BYTE_W-1:0] hay_rd, ndl_rd;

    logic signed [SW-1:0]       hay_x, ndl_x, ofs_x, hi_x, sfx_x, top_x, lo_x;
    logic                       early;
    logic [lspos_pkg::STAT_W-1:0] e_status;
    logic [lspos_pkg::POS_W-1:0]  e_pos;

    // ---------------- stores ----------------
    assign hay_full = (r_hay_len == HL_W'(MAX_HAYSTACK));
    assign ndl_full = (r_ndl_len == NL_W'(MAX_NEEDLE));
    assign hay_we   = i_cmd.load && (i_kind == lspos_pkg::KIND_HAYSTACK) && !hay_full;
    assign ndl_we   = i_cmd.load && (i_kind == lspos_pkg::KIND_NEEDLE) && !ndl_full;
    assign hay_rd_addr = r_cand + HA_W'(r_k);

    lspos_ram #(.WIDTH(lspos_pkg::BYTE_W), .DEPTH(MAX_HAYSTACK)) u_hay_ram (
        .i_clk     (i_clk),
        .i_wr_en   (hay_we),
        .i_wr_addr (HA_W'(r_hay_len)),
        .i_wr_data (i_byte_value),
        .i_rd_addr (hay_rd_addr),
        .o_rd_data (hay_rd)
    );

    lspos_ram #(.WIDTH(lspos_pkg::BYTE_W), .DEPTH(MAX_NEEDLE)) u_ndl_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ndl_we),
        .i_wr_addr (NA_W'(r_ndl_len)),
        .i_wr_data (i_byte_value),
        .i_rd_addr (r_k),
        .o_rd_data (ndl_rd)
    );

    // ---------------- range setup ----------------
    always_comb begin
        hay_x    = $signed({{(SW-HL_W){1'b0}}, r_hay_len});
        ndl_x    = $signed({{(SW-NL_W){1'b0}}, r_ndl_len});
        ofs_x    = $signed({{(SW-lspos_pkg::OFS_W){r_ofs[lspos_pkg::OFS_W-1]}}, r_ofs});
        hi_x     = hay_x - ndl_x;
        sfx_x    = hay_x + ofs_x;
        top_x    = hi_x;
        lo_x     = '0;
        early    = 1'b0;
        e_status = lspos_pkg::ST_NONE;
        e_pos    = '0;
        if (r_ovf) begin
            early    = 1'b1;
            e_status = lspos_pkg::ST_LONG;
        end else if ((r_ndl_len == '0) || (hay_x < ndl_x)) begin
            early = 1'b1;
        end else if (ofs_x < 0) begin
            if (sfx_x < 0) begin
                early    = 1'b1;
                e_status = lspos_pkg::ST_RANGE;
                e_pos    = '1;
            end else if (sfx_x < hi_x) begin
                top_x = sfx_x;
            end
        end else if (ofs_x > hi_x) begin
            early = 1'b1;
        end else begin
            lo_x = ofs_x;
        end
    end

    // ---------------- status to controller ----------------
    assign o_sts.early     = early;
    assign o_sts.match     = (hay_rd == ndl_rd);
    assign o_sts.last_byte = ((NL_W'(r_k) + NL_W'(1)) == r_ndl_len);
    assign o_sts.at_lo     = (r_cand == r_lo);
    assign o_sts.out_free  = !r_out_valid || !i_stall;

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hay_len   <= '0;
            r_ndl_len   <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load && (i_kind == lspos_pkg::KIND_HAYSTACK)) begin
                if (hay_full) r_ovf <= 1'b1;
                else          r_hay_len <= r_hay_len + HL_W'(1);
            end
            if (i_cmd.load && (i_kind == lspos_pkg::KIND_NEEDLE)) begin
                if (ndl_full) r_ovf <= 1'b1;
                else          r_ndl_len <= r_ndl_len + NL_W'(1);
            end
            if (i_cmd.finish) begin
                r_hay_len   <= '0;
                r_ndl_len   <= '0;
                r_ovf       <= 1'b0;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------- search and result payload ----------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_ofs <= i_search_offset;
        end
        if (i_cmd.setup) begin
            r_cand       <= HA_W'(top_x);
            r_lo         <= HA_W'(lo_x);
            r_k          <= '0;
            r_res_pos    <= e_pos;
            r_res_status <= e_status;
        end
        if (i_cmd.step) begin
            if (o_sts.match) begin
                if (o_sts.last_byte) begin
                    r_res_status <= lspos_pkg::ST_FOUND;
                    r_res_pos    <= lspos_pkg::POS_W'(r_cand);
                end else begin
                    r_k <= r_k + NA_W'(1);
                end
            end else if (!o_sts.at_lo) begin
                r_cand <= r_cand - HA_W'(1);
                r_k    <= '0;
            end
        end
        if (i_cmd.finish) begin
            r_out_pos    <= $signed(r_res_pos);
            r_out_status <= r_res_status;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_position = r_out_pos;
    assign o_status   = r_out_status;

    // ---------------- assertions ----------------
    a_clear_on_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> (r_hay_len == '0) && (r_ndl_len == '0) && !r_ovf)
        else $error("strings not cleared after finish");

    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> ((HW'(r_cand) + HW'(r_k)) < HW'(r_hay_len)))
        else $error("haystack read beyond stored length");

    a_cand_not_below_lo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> (r_cand >= r_lo))
        else $error("candidate walked below earliest start");

    a_result_delivered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> o_valid && (o_status == $past(r_res_status)))
        else $error("result not moved to output");

endmodule

// File: src/last_substring_position_core.sv
// ----------------------------------------------------------------------------
// last_substring_position_core
// Last-occurrence substring search: needle and haystack bytes stream into
// two RAMs; a finish word with a signed offset returns the last start of
// the needle inside the allowed range, then clears both strings.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake          | word fields
//  --------+-----+--------------------+--------------------------------------
//  input   | in  | i_valid / o_stall  | i_kind, i_byte_value, i_search_offset
//  result  | out | o_valid / i_stall  | o_position, o_status
//
//  Needle and haystack byte words are taken while idle, each as one RAM write.
//  A finish word stalls the input through setup, a read state and a
//    compare state per byte pair (registered RAM read port), and done.
//    The byte pairs compared are at most (candidates) * (needle length).
//  Candidates are walked from the latest start downward and the walk stops
//    at the first full match; each candidate is left at its first mismatch.
//  Synchronous active-low reset clears lengths, overflow flag, FSM and the
//    output valid; RAM contents are left as they are (no clearing pass).
//  A waiting result does not block byte words; a finish word waits in its
//    last cycle until the output register is free.
//
module last_substring_position_core #(
    parameter int MAX_HAYSTACK = 4096,
    parameter int MAX_NEEDLE   = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input words
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [lspos_pkg::KIND_W-1:0]        i_kind,
    input  logic [lspos_pkg::BYTE_W-1:0]        i_byte_value,
    input  logic signed [lspos_pkg::OFS_W-1:0]  i_search_offset,
    // result words
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [lspos_pkg::POS_W-1:0]  o_position,
    output logic [lspos_pkg::STAT_W-1:0]        o_status
);

    lspos_pkg::t_cmd cmd;
    lspos_pkg::t_sts sts;

    // sequencer: owns the input handshake
    lspos_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_kind  (i_kind),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // stores, search datapath and output register
    lspos_dp #(
        .MAX_HAYSTACK (MAX_HAYSTACK),
        .MAX_NEEDLE   (MAX_NEEDLE)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_kind          (i_kind),
        .i_byte_value    (i_byte_value),
        .i_search_offset (i_search_offset),
        .i_stall         (i_stall),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_valid         (o_valid),
        .o_position      (o_position),
        .o_status        (o_status)
    );

endmodule
